### src/firp_pkg.sv
// ----------------------------------------------------------------------------
// firp_pkg: shared definitions for the fused inverted residual pixel block
// Command and register codes, stage and sequencer types, width helpers and
// the shift-and-saturate function used at the end of every stage.
// ----------------------------------------------------------------------------
package firp_pkg;

  typedef enum logic [2:0] {
    CMD_PATCH   = 3'd0,
    CMD_EW      = 3'd1,
    CMD_EB      = 3'd2,
    CMD_DWW     = 3'd3,
    CMD_DWB     = 3'd4,
    CMD_PW      = 3'd5,
    CMD_PB      = 3'd6,
    CMD_RUN     = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    REG_IN_CH    = 3'd0,
    REG_MID_CH   = 3'd1,
    REG_OUT_CH   = 3'd2,
    REG_EXP_SH   = 3'd3,
    REG_DW_SH    = 3'd4,
    REG_PROJ_SH  = 3'd5
  } reg_idx_t;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_BIAS_RD = 6'b000010,
    S_BIAS_LD = 6'b000100,
    S_MAC_RD  = 6'b001000,
    S_MAC_ACC = 6'b010000,
    S_WB      = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    STG_EXP  = 3'b001,
    STG_DW   = 3'b010,
    STG_PROJ = 3'b100
  } stage_t;

  localparam int NUM_STORES = 7;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Address width of a memory of the given depth (at least one bit).
  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Arithmetic right shift of a 32-bit accumulator, then clamp to int8.
  function automatic logic [7:0] shift_sat(input logic [31:0] acc,
                                           input logic [4:0]  sh);
    logic signed [31:0] v;
    v = $signed(acc) >>> sh;
    if (v > 32'sd127) begin
      return 8'h7F;
    end else if (v < -32'sd128) begin
      return 8'h80;
    end
    return v[7:0];
  endfunction

endpackage

### src/fused_inverted_residual_pixel.sv
// ----------------------------------------------------------------------------
// fused_inverted_residual_pixel: one output pixel of an int8 inverted residual
// 1x1 expansion, 3x3 depthwise and 1x1 projection computed by one shared
// multiply-accumulate unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage. A command transaction is taken at a rising edge with start high and
// busy low. Commands 0..6 push value into one of the seven stores (patch,
// expansion weights/biases, depthwise weights/biases, projection
// weights/biases); pushes can be issued every cycle, and a push into a full
// store is dropped. Command 7 runs the pixel: busy rises the next cycle and
// stays high while the single 8x8 multiplier and 32-bit accumulator walk the
// stores. Each multiply-accumulate is a RAM read, then an accumulate, and each
// output of a stage adds a bias read, a bias load and a shift/saturate
// write-back. Results are one-cycle strobes on result_valid with out_value and
// last; last marks the final output channel, and busy is already low and all
// store pointers are back at zero when it is shown. The receiver cannot stall;
// nothing is buffered.
// Configuration writes (cfg_valid, cfg_ready always high) must be made while
// busy is low. Synchronous reset returns the channel counts to 1, the shifts
// to 0 and the pointers to 0; store contents are not cleared.
// ----------------------------------------------------------------------------
module fused_inverted_residual_pixel #(
  parameter int MAX_IN_CH   = 16,
  parameter int MAX_MID_CH  = 64,
  parameter int MAX_OUT_CH  = 32,
  parameter int KERNEL_TAPS = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [31:0] value,
  output logic        result_valid,
  output logic [7:0]  out_value,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Store capacities, in the order of the push commands.
  localparam int CAP_PATCH = KERNEL_TAPS * MAX_IN_CH;
  localparam int CAP_EW    = MAX_MID_CH * MAX_IN_CH;
  localparam int CAP_EB    = MAX_MID_CH;
  localparam int CAP_DWW   = KERNEL_TAPS * MAX_MID_CH;
  localparam int CAP_DWB   = MAX_MID_CH;
  localparam int CAP_PW    = MAX_OUT_CH * MAX_MID_CH;
  localparam int CAP_PB    = MAX_OUT_CH;
  localparam int CAP_XB    = KERNEL_TAPS * MAX_MID_CH;
  localparam int CAP_MAX   = firp_pkg::imax(firp_pkg::imax(
                               firp_pkg::imax(CAP_PATCH, CAP_EW),
                               firp_pkg::imax(CAP_DWW, CAP_PW)),
                               firp_pkg::imax(CAP_EB, CAP_PB));

  localparam int PW_W   = $clog2(CAP_MAX + 1);
  localparam int AW     = PW_W;
  localparam int NIN_W  = $clog2(MAX_IN_CH + 1);
  localparam int NMID_W = $clog2(MAX_MID_CH + 1);
  localparam int NOUT_W = $clog2(MAX_OUT_CH + 1);
  localparam int TW     = $clog2(KERNEL_TAPS + 1);
  localparam int KW     = $clog2(firp_pkg::imax(firp_pkg::imax(MAX_IN_CH, KERNEL_TAPS),
                                                MAX_MID_CH) + 1);

  localparam int PATCH_AW = firp_pkg::addr_w(CAP_PATCH);
  localparam int EW_AW    = firp_pkg::addr_w(CAP_EW);
  localparam int EB_AW    = firp_pkg::addr_w(CAP_EB);
  localparam int DWW_AW   = firp_pkg::addr_w(CAP_DWW);
  localparam int DWB_AW   = firp_pkg::addr_w(CAP_DWB);
  localparam int PW_AW    = firp_pkg::addr_w(CAP_PW);
  localparam int PB_AW    = firp_pkg::addr_w(CAP_PB);
  localparam int XB_AW    = firp_pkg::addr_w(CAP_XB);
  localparam int DB_AW    = firp_pkg::addr_w(MAX_MID_CH);

  // Configuration registers.
  logic [4:0] in_channels;
  logic [6:0] mid_channels;
  logic [5:0] out_channels;
  logic [4:0] expand_shift;
  logic [4:0] dw_shift;
  logic [4:0] proj_shift;

  // Sequencer state.
  firp_pkg::state_t state;
  firp_pkg::stage_t stage;
  logic [PW_W-1:0]  wp [firp_pkg::NUM_STORES];
  logic [TW-1:0]    t;
  logic [NMID_W-1:0] e;
  logic [NOUT_W-1:0] o;
  logic [KW-1:0]    k;
  logic [AW-1:0]    pbase;
  logic [AW-1:0]    wbase;
  logic [AW-1:0]    xbase;
  logic [AW-1:0]    obase;
  logic [AW-1:0]    addr_a;
  logic [AW-1:0]    addr_b;
  logic [31:0]      acc;

  // Derived control values.
  logic [NIN_W-1:0]  nin;
  logic [NMID_W-1:0] nmid;
  logic [NOUT_W-1:0] nout;
  logic [KW-1:0]     klim;
  logic [AW-1:0]     step_a;
  logic [AW-1:0]     step_b;
  logic [4:0]        cur_shift;
  logic [7:0]        sat;
  logic [PW_W-1:0]   cur_ptr;
  logic [PW_W-1:0]   cur_cap;
  logic              push;
  logic              push_ok;
  logic              run_go;

  // Memory ports.
  logic [7:0]  patch_q, ew_q, dww_q, pw_q, xb_q, dbuf_q;
  logic [31:0] eb_q, dwb_q, pb_q;
  logic [7:0]  op_a, op_b;
  logic signed [15:0] prod;
  logic [31:0] bias_q;
  logic [AW-1:0] bias_addr;
  logic [AW-1:0] xb_waddr;

  assign busy      = (state != firp_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign push      = start && !busy && (cmd != firp_pkg::CMD_RUN);
  assign run_go    = start && !busy && (cmd == firp_pkg::CMD_RUN);

  // Channel counts as used: zero counts as one, excess counts clamp.
  always_comb begin
    if (in_channels == '0) begin
      nin = NIN_W'(1);
    end else if (in_channels > MAX_IN_CH) begin
      nin = NIN_W'(MAX_IN_CH);
    end else begin
      nin = NIN_W'(in_channels);
    end
    if (mid_channels == '0) begin
      nmid = NMID_W'(1);
    end else if (mid_channels > MAX_MID_CH) begin
      nmid = NMID_W'(MAX_MID_CH);
    end else begin
      nmid = NMID_W'(mid_channels);
    end
    if (out_channels == '0) begin
      nout = NOUT_W'(1);
    end else if (out_channels > MAX_OUT_CH) begin
      nout = NOUT_W'(MAX_OUT_CH);
    end else begin
      nout = NOUT_W'(out_channels);
    end
  end

  // Pointer and capacity of the store addressed by the current push.
  always_comb begin
    unique case (cmd)
      firp_pkg::CMD_PATCH: begin cur_ptr = wp[0]; cur_cap = PW_W'(CAP_PATCH); end
      firp_pkg::CMD_EW:    begin cur_ptr = wp[1]; cur_cap = PW_W'(CAP_EW);    end
      firp_pkg::CMD_EB:    begin cur_ptr = wp[2]; cur_cap = PW_W'(CAP_EB);    end
      firp_pkg::CMD_DWW:   begin cur_ptr = wp[3]; cur_cap = PW_W'(CAP_DWW);   end
      firp_pkg::CMD_DWB:   begin cur_ptr = wp[4]; cur_cap = PW_W'(CAP_DWB);   end
      firp_pkg::CMD_PW:    begin cur_ptr = wp[5]; cur_cap = PW_W'(CAP_PW);    end
      firp_pkg::CMD_PB:    begin cur_ptr = wp[6]; cur_cap = PW_W'(CAP_PB);    end
      default:             begin cur_ptr = '0;    cur_cap = '0;               end
    endcase
  end
  assign push_ok = push && (cur_ptr < cur_cap);

  // Per-stage selection of operands, strides, trip count and shift.
  always_comb begin
    unique case (stage)
      firp_pkg::STG_EXP: begin
        op_a = patch_q;  op_b = ew_q;   bias_q = eb_q;
        step_a = AW'(1); step_b = AW'(1);
        klim = KW'(nin); cur_shift = expand_shift;
        bias_addr = AW'(e);
      end
      firp_pkg::STG_DW: begin
        op_a = xb_q;     op_b = dww_q;  bias_q = dwb_q;
        step_a = AW'(MAX_MID_CH); step_b = AW'(nmid);
        klim = KW'(KERNEL_TAPS); cur_shift = dw_shift;
        bias_addr = AW'(e);
      end
      default: begin
        op_a = dbuf_q;   op_b = pw_q;   bias_q = pb_q;
        step_a = AW'(1); step_b = AW'(1);
        klim = KW'(nmid); cur_shift = proj_shift;
        bias_addr = AW'(o);
      end
    endcase
  end

  assign prod     = $signed(op_a) * $signed(op_b);
  assign sat      = firp_pkg::shift_sat(acc, cur_shift);
  assign xb_waddr = xbase + AW'(e);

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_channels  <= 5'd1;
      mid_channels <= 7'd1;
      out_channels <= 6'd1;
      expand_shift <= '0;
      dw_shift     <= '0;
      proj_shift   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        firp_pkg::REG_IN_CH:   in_channels  <= cfg_data[4:0];
        firp_pkg::REG_MID_CH:  mid_channels <= cfg_data[6:0];
        firp_pkg::REG_OUT_CH:  out_channels <= cfg_data[5:0];
        firp_pkg::REG_EXP_SH:  expand_shift <= cfg_data[4:0];
        firp_pkg::REG_DW_SH:   dw_shift     <= cfg_data[4:0];
        firp_pkg::REG_PROJ_SH: proj_shift   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Sequencer: bias read, bias load, then read/accumulate pairs, then
  // write-back with shift and saturation; the stage and the outer
  // counters advance at write-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= firp_pkg::S_IDLE;
      stage        <= firp_pkg::STG_EXP;
      result_valid <= 1'b0;
      for (int j = 0; j < firp_pkg::NUM_STORES; j++) begin
        wp[j] <= '0;
      end
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        firp_pkg::S_IDLE: begin
          if (push_ok) begin
            for (int j = 0; j < firp_pkg::NUM_STORES; j++) begin
              if (cmd == 3'(j)) begin
                wp[j] <= wp[j] + PW_W'(1);
              end
            end
          end
          if (run_go) begin
            stage <= firp_pkg::STG_EXP;
            t     <= '0;
            e     <= '0;
            o     <= '0;
            pbase <= '0;
            wbase <= '0;
            xbase <= '0;
            obase <= '0;
            state <= firp_pkg::S_BIAS_RD;
          end
        end
        firp_pkg::S_BIAS_RD: begin
          state <= firp_pkg::S_BIAS_LD;
        end
        firp_pkg::S_BIAS_LD: begin
          acc <= bias_q;
          k   <= '0;
          unique case (stage)
            firp_pkg::STG_EXP: begin addr_a <= pbase;   addr_b <= wbase;   end
            firp_pkg::STG_DW:  begin addr_a <= AW'(e);  addr_b <= AW'(e);  end
            default:           begin addr_a <= '0;      addr_b <= obase;   end
          endcase
          state <= firp_pkg::S_MAC_RD;
        end
        firp_pkg::S_MAC_RD: begin
          state <= firp_pkg::S_MAC_ACC;
        end
        firp_pkg::S_MAC_ACC: begin
          acc    <= acc + {{16{prod[15]}}, prod};
          k      <= k + KW'(1);
          addr_a <= addr_a + step_a;
          addr_b <= addr_b + step_b;
          state  <= (k == klim - KW'(1)) ? firp_pkg::S_WB : firp_pkg::S_MAC_RD;
        end
        firp_pkg::S_WB: begin
          state <= firp_pkg::S_BIAS_RD;
          unique case (stage)
            firp_pkg::STG_EXP: begin
              if (e == nmid - NMID_W'(1)) begin
                e     <= '0;
                wbase <= '0;
                if (t == TW'(KERNEL_TAPS - 1)) begin
                  stage <= firp_pkg::STG_DW;
                end else begin
                  t     <= t + TW'(1);
                  pbase <= pbase + AW'(nin);
                  xbase <= xbase + AW'(MAX_MID_CH);
                end
              end else begin
                e     <= e + NMID_W'(1);
                wbase <= wbase + AW'(nin);
              end
            end
            firp_pkg::STG_DW: begin
              if (e == nmid - NMID_W'(1)) begin
                stage <= firp_pkg::STG_PROJ;
              end else begin
                e <= e + NMID_W'(1);
              end
            end
            default: begin
              result_valid <= 1'b1;
              out_value    <= sat;
              if (o == nout - NOUT_W'(1)) begin
                last  <= 1'b1;
                state <= firp_pkg::S_IDLE;
                for (int j = 0; j < firp_pkg::NUM_STORES; j++) begin
                  wp[j] <= '0;
                end
              end else begin
                last  <= 1'b0;
                o     <= o + NOUT_W'(1);
                obase <= obase + AW'(nmid);
              end
            end
          endcase
        end
        default: state <= firp_pkg::S_IDLE;
      endcase
    end
  end

  // Stores, written by pushes while idle and read by the sequencer.
  firp_ram #(.WIDTH(8), .DEPTH(CAP_PATCH)) u_patch (
    .clk, .wr_en(push_ok && cmd == firp_pkg::CMD_PATCH),
    .wr_addr(cur_ptr[PATCH_AW-1:0]), .wr_data(value[7:0]),
    .rd_addr(addr_a[PATCH_AW-1:0]), .rd_data(patch_q));

  firp_ram #(.WIDTH(8), .DEPTH(CAP_EW)) u_ew (
    .clk, .wr_en(push_ok && cmd == firp_pkg::CMD_EW),
    .wr_addr(cur_ptr[EW_AW-1:0]), .wr_data(value[7:0]),
    .rd_addr(addr_b[EW_AW-1:0]), .rd_data(ew_q));

  firp_ram #(.WIDTH(32), .DEPTH(CAP_EB)) u_eb (
    .clk, .wr_en(push_ok && cmd == firp_pkg::CMD_EB),
    .wr_addr(cur_ptr[EB_AW-1:0]), .wr_data(value),
    .rd_addr(bias_addr[EB_AW-1:0]), .rd_data(eb_q));

  firp_ram #(.WIDTH(8), .DEPTH(CAP_DWW)) u_dww (
    .clk, .wr_en(push_ok && cmd == firp_pkg::CMD_DWW),
    .wr_addr(cur_ptr[DWW_AW-1:0]), .wr_data(value[7:0]),
    .rd_addr(addr_b[DWW_AW-1:0]), .rd_data(dww_q));

  firp_ram #(.WIDTH(32), .DEPTH(CAP_DWB)) u_dwb (
    .clk, .wr_en(push_ok && cmd == firp_pkg::CMD_DWB),
    .wr_addr(cur_ptr[DWB_AW-1:0]), .wr_data(value),
    .rd_addr(bias_addr[DWB_AW-1:0]), .rd_data(dwb_q));

  firp_ram #(.WIDTH(8), .DEPTH(CAP_PW)) u_pw (
    .clk, .wr_en(push_ok && cmd == firp_pkg::CMD_PW),
    .wr_addr(cur_ptr[PW_AW-1:0]), .wr_data(value[7:0]),
    .rd_addr(addr_b[PW_AW-1:0]), .rd_data(pw_q));

  firp_ram #(.WIDTH(32), .DEPTH(CAP_PB)) u_pb (
    .clk, .wr_en(push_ok && cmd == firp_pkg::CMD_PB),
    .wr_addr(cur_ptr[PB_AW-1:0]), .wr_data(value),
    .rd_addr(bias_addr[PB_AW-1:0]), .rd_data(pb_q));

  // Intermediate buffers, written on write-back of the first two stages.
  firp_ram #(.WIDTH(8), .DEPTH(CAP_XB)) u_xbuf (
    .clk,
    .wr_en(state == firp_pkg::S_WB && stage == firp_pkg::STG_EXP),
    .wr_addr(xb_waddr[XB_AW-1:0]), .wr_data(sat),
    .rd_addr(addr_a[XB_AW-1:0]), .rd_data(xb_q));

  firp_ram #(.WIDTH(8), .DEPTH(MAX_MID_CH)) u_dbuf (
    .clk,
    .wr_en(state == firp_pkg::S_WB && stage == firp_pkg::STG_DW),
    .wr_addr(e[DB_AW-1:0]), .wr_data(sat),
    .rd_addr(addr_a[DB_AW-1:0]), .rd_data(dbuf_q));

endmodule

### src/firp_ram.sv
// ----------------------------------------------------------------------------
// firp_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module firp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [firp_pkg::addr_w(DEPTH)-1:0]      wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [firp_pkg::addr_w(DEPTH)-1:0]      rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/firp_checker.sv
// ----------------------------------------------------------------------------
// firp_checker: port-level checks for the fused inverted residual pixel
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module firp_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [2:0] cmd,
  input logic       result_valid,
  input logic       last
);

  // A run transaction makes the block busy on the next cycle.
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd == firp_pkg::CMD_RUN |=> busy)
    else $error("run transaction did not raise busy");

  // A push transaction does not raise busy.
  a_push_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd != firp_pkg::CMD_RUN |=> !busy)
    else $error("push transaction raised busy");

  // Results come only out of a run in progress.
  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a run");

  // More results pending keep the block busy; the final one is alone.
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> busy)
    else $error("block went idle before the final result");

  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid)
    else $error("result followed the final result");

endmodule

bind fused_inverted_residual_pixel firp_checker u_firp_checker (.*);
